[hw/rtl/cau_pkg.sv]
// Shared types and constants for the complex arithmetic unit.
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2,
		ST_RSVD = 2'd3
	} status_t;

	// Classification that travels with each operand set.
	typedef struct packed {
		op_t  op;
		logic b_zero;
	} item_ctl_t;

endpackage

[hw/rtl/cau_front.sv]
// Front end: accept transactions, classify them and hold them in a two-entry queue.
module cau_front #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	input  logic                         take,
	output logic                         head_v,
	output cau_pkg::item_ctl_t           head_ctl,
	output logic signed [DATA_WIDTH-1:0] head_a_re,
	output logic signed [DATA_WIDTH-1:0] head_a_im,
	output logic signed [DATA_WIDTH-1:0] head_b_re,
	output logic signed [DATA_WIDTH-1:0] head_b_im
);
	import cau_pkg::*;

	item_ctl_t                   ctl_q  [2];
	logic signed [DATA_WIDTH-1:0] a_re_q [2];
	logic signed [DATA_WIDTH-1:0] a_im_q [2];
	logic signed [DATA_WIDTH-1:0] b_re_q [2];
	logic signed [DATA_WIDTH-1:0] b_im_q [2];
	logic                        wr_ptr_q;
	logic                        rd_ptr_q;
	logic [1:0]                  cnt_q;
	logic                        wr_en;
	logic                        rd_en;
	item_ctl_t                   ctl_in;

	assign full   = (cnt_q == 2'd2);
	assign head_v = (cnt_q != 2'd0);
	assign wr_en  = push && !full;
	assign rd_en  = take && head_v;

	always_comb begin
		ctl_in.op     = op_t'(action);
		ctl_in.b_zero = (b_re == '0) && (b_im == '0);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ctl_q[wr_ptr_q]  <= ctl_in;
			a_re_q[wr_ptr_q] <= a_re;
			a_im_q[wr_ptr_q] <= a_im;
			b_re_q[wr_ptr_q] <= b_re;
			b_im_q[wr_ptr_q] <= b_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_ctl  = ctl_q[rd_ptr_q];
	assign head_a_re = a_re_q[rd_ptr_q];
	assign head_a_im = a_im_q[rd_ptr_q];
	assign head_b_re = b_re_q[rd_ptr_q];
	assign head_b_im = b_im_q[rd_ptr_q];

endmodule

[hw/rtl/cau_qdiv.sv]
// Pipelined restoring divider: (mag * 2^FRAC_BITS) / den, one quotient bit per stage.
module cau_qdiv #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    adv,
	input  logic [2*DATA_WIDTH-1:0] mag,
	input  logic [2*DATA_WIDTH-1:0] den,
	output logic [DATA_WIDTH-1:0]   quo,
	output logic                    big
);
	localparam int W  = DATA_WIDTH;
	localparam int XW = 2*W + FRAC_BITS;
	localparam int RW = 2*W + 1;

	logic [XW-1:0]  x;
	logic [XW-1:0]  hi;
	logic           big0;
	logic [RW-1:0]  rem_s [W+1];
	logic [W-1:0]   xl_s  [W+1];
	logic [2*W-1:0] den_s [W+1];
	logic [W-1:0]   quo_s [W+1];
	logic           big_s [W+1];

	assign x    = XW'(mag) << FRAC_BITS;
	assign hi   = x >> W;
	// quotient of 2^W or more: saturate regardless of the low bits
	assign big0 = (hi >= XW'(den));

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s[0] <= big0 ? '0 : RW'(hi);
			xl_s[0]  <= x[W-1:0];
			den_s[0] <= den;
			quo_s[0] <= '0;
			big_s[0] <= big0;
		end
	end

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [RW-1:0] shifted;
		logic          ge;

		assign shifted = {rem_s[i][RW-2:0], xl_s[i][W-1-i]};
		assign ge      = (shifted >= {1'b0, den_s[i]});

		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1] <= ge ? (shifted - {1'b0, den_s[i]}) : shifted;
				xl_s[i+1]  <= xl_s[i];
				den_s[i+1] <= den_s[i];
				quo_s[i+1] <= quo_s[i] | (ge ? (W'(1) << (W-1-i)) : '0);
				big_s[i+1] <= big_s[i];
			end
		end
	end

	assign quo = quo_s[W];
	assign big = big_s[W];

endmodule

[hw/rtl/cau_back.sv]
// Back end: product stage, combine stage, divider pipeline, saturation and result register.
module cau_back #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         head_v,
	input  cau_pkg::item_ctl_t           head_ctl,
	input  logic signed [DATA_WIDTH-1:0] head_a_re,
	input  logic signed [DATA_WIDTH-1:0] head_a_im,
	input  logic signed [DATA_WIDTH-1:0] head_b_re,
	input  logic signed [DATA_WIDTH-1:0] head_b_im,
	output logic                         take,
	input  logic                         pop,
	output logic                         empty,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);
	import cau_pkg::*;

	localparam int W  = DATA_WIDTH;
	localparam int PW = 2*W + 1;
	localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

	logic adv;

	// stage 1: products and add/subtract
	logic                  v_s1;
	item_ctl_t             ctl_s1;
	logic signed [W:0]     sum_re_s1, sum_im_s1;
	logic signed [2*W-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;

	// stage 2: combined values, divider operands
	logic                  v_s2;
	item_ctl_t             ctl_s2;
	logic signed [PW-1:0]  val_re_s2, val_im_s2;
	logic [2*W-1:0]        mag_re_s2, mag_im_s2, den_s2;
	logic                  neg_re_s2, neg_im_s2;

	// side band aligned with the divider
	logic                  sv_q     [W+2];
	item_ctl_t             sctl_q   [W+2];
	logic signed [PW-1:0]  sre_q    [W+2];
	logic signed [PW-1:0]  sim_q    [W+2];
	logic                  sneg_r_q [W+2];
	logic                  sneg_i_q [W+2];

	logic [W-1:0]          quo_re, quo_im;
	logic                  big_re, big_im;

	logic                  out_v_q;
	logic [W-1:0]          res_re_q, res_im_q;
	status_t               status_q;

	assign adv   = !out_v_q || pop;
	assign take  = adv && head_v;
	assign empty = !out_v_q;

	function automatic logic signed [PW-1:0] ext_p(input logic signed [2*W-1:0] p);
		return {p[2*W-1], p};
	endfunction

	// divide by 2^FRAC_BITS, truncating toward zero
	function automatic logic signed [PW-1:0] scale(input logic signed [PW-1:0] v);
		logic [PW-1:0] bias;
		bias = v[PW-1] ? ((PW'(1) << FRAC_BITS) - PW'(1)) : '0;
		return (v + $signed(bias)) >>> FRAC_BITS;
	endfunction

	function automatic logic [2*W-1:0] magn(input logic signed [PW-1:0] v);
		logic [PW-1:0] a;
		a = v[PW-1] ? (-v) : v;
		return a[2*W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= head_ctl;
			if (head_ctl.op == OP_SUB) begin
				sum_re_s1 <= {head_a_re[W-1], head_a_re} - {head_b_re[W-1], head_b_re};
				sum_im_s1 <= {head_a_im[W-1], head_a_im} - {head_b_im[W-1], head_b_im};
			end else begin
				sum_re_s1 <= {head_a_re[W-1], head_a_re} + {head_b_re[W-1], head_b_re};
				sum_im_s1 <= {head_a_im[W-1], head_a_im} + {head_b_im[W-1], head_b_im};
			end
			p_rr_s1 <= head_a_re * head_b_re;
			p_ii_s1 <= head_a_im * head_b_im;
			p_ri_s1 <= head_a_re * head_b_im;
			p_ir_s1 <= head_a_im * head_b_re;
			p_bb_s1 <= head_b_re * head_b_re;
			p_cc_s1 <= head_b_im * head_b_im;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] n_re, n_im, d;
		n_re = ext_p(p_rr_s1) + ext_p(p_ii_s1);
		n_im = ext_p(p_ir_s1) - ext_p(p_ri_s1);
		d    = ext_p(p_bb_s1) + ext_p(p_cc_s1);
		if (adv) begin
			ctl_s2 <= ctl_s1;
			case (ctl_s1.op)
				OP_MUL: begin
					val_re_s2 <= scale(ext_p(p_rr_s1) - ext_p(p_ii_s1));
					val_im_s2 <= scale(ext_p(p_ri_s1) + ext_p(p_ir_s1));
				end
				default: begin
					val_re_s2 <= {{W{sum_re_s1[W]}}, sum_re_s1};
					val_im_s2 <= {{W{sum_im_s1[W]}}, sum_im_s1};
				end
			endcase
			mag_re_s2 <= magn(n_re);
			mag_im_s2 <= magn(n_im);
			neg_re_s2 <= n_re[PW-1];
			neg_im_s2 <= n_im[PW-1];
			den_s2    <= d[2*W-1:0];
		end
	end

	cau_qdiv #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_re (
		.clk (clk),
		.adv (adv),
		.mag (mag_re_s2),
		.den (den_s2),
		.quo (quo_re),
		.big (big_re)
	);

	cau_qdiv #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_im (
		.clk (clk),
		.adv (adv),
		.mag (mag_im_s2),
		.den (den_s2),
		.quo (quo_im),
		.big (big_im)
	);

	// side band: index 0 is stage 2, index W+1 lines up with the divider output
	assign sv_q[0]     = v_s2;
	assign sctl_q[0]   = ctl_s2;
	assign sre_q[0]    = val_re_s2;
	assign sim_q[0]    = val_im_s2;
	assign sneg_r_q[0] = neg_re_s2;
	assign sneg_i_q[0] = neg_im_s2;

	for (genvar k = 0; k <= W; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (adv) begin
				sctl_q[k+1]   <= sctl_q[k];
				sre_q[k+1]    <= sre_q[k];
				sim_q[k+1]    <= sim_q[k];
				sneg_r_q[k+1] <= sneg_r_q[k];
				sneg_i_q[k+1] <= sneg_i_q[k];
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sv_q[k+1] <= 1'b0;
			end else if (adv) begin
				sv_q[k+1] <= sv_q[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= head_v;
			v_s2    <= v_s1;
			out_v_q <= sv_q[W+1];
		end
	end

	// saturation of a wide signed value
	function automatic logic [W:0] sat_wide(input logic signed [PW-1:0] v);
		logic fits;
		fits = (v[PW-1:W-1] == '0) || (v[PW-1:W-1] == '1);
		if (fits) return {1'b0, v[W-1:0]};
		return {1'b1, v[PW-1] ? MINV : MAXV};
	endfunction

	// signed saturation of a divider quotient
	function automatic logic [W:0] sat_quo(input logic [W-1:0] q, input logic b,
			input logic n);
		logic ovf;
		if (n) ovf = b || (q[W-1] && (q[W-2:0] != '0));
		else   ovf = b || q[W-1];
		if (ovf) return {1'b1, n ? MINV : MAXV};
		return {1'b0, n ? (-q) : q};
	endfunction

	always_ff @(posedge clk) begin
		logic [W:0] r_re, r_im;
		if (sctl_q[W+1].op == OP_DIV) begin
			r_re = sat_quo(quo_re, big_re, sneg_r_q[W+1]);
			r_im = sat_quo(quo_im, big_im, sneg_i_q[W+1]);
		end else begin
			r_re = sat_wide(sre_q[W+1]);
			r_im = sat_wide(sim_q[W+1]);
		end
		if (adv) begin
			if (sctl_q[W+1].op == OP_DIV && sctl_q[W+1].b_zero) begin
				res_re_q <= '0;
				res_im_q <= '0;
				status_q <= ST_DIV0;
			end else begin
				res_re_q <= r_re[W-1:0];
				res_im_q <= r_im[W-1:0];
				status_q <= (r_re[W] || r_im[W]) ? ST_OVF : ST_OK;
			end
		end
	end

	assign res_re = res_re_q;
	assign res_im = res_im_q;
	assign status = status_q;

endmodule

[hw/rtl/complex_arithmetic_unit.sv]
// Top level of the complex arithmetic unit: front queue and back-end pipeline.
//
//  channel   handshake            payload
//  input     push / full          action, a_re, a_im, b_re, b_im
//  result    empty / pop          res_re, res_im, status
//
// One transaction is accepted per cycle and one result delivered per cycle while nothing stalls
// (full low, pop high). The divider pipeline computes one quotient bit per stage.
// Reset clears the queue and all valid bits; no clearing pass is needed.
// A held result (empty low, pop low) freezes the whole back end; the two-entry
// front queue keeps taking transactions until it fills, then raises full.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   action,
	input  logic signed [DATA_WIDTH-1:0] a_re,
	input  logic signed [DATA_WIDTH-1:0] a_im,
	input  logic signed [DATA_WIDTH-1:0] b_re,
	input  logic signed [DATA_WIDTH-1:0] b_im,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [DATA_WIDTH-1:0] res_re,
	output logic signed [DATA_WIDTH-1:0] res_im,
	output logic [1:0]                   status
);
	import cau_pkg::*;

	// queue head handed to the back end
	logic                         head_v;
	item_ctl_t                    head_ctl;
	logic signed [DATA_WIDTH-1:0] head_a_re, head_a_im, head_b_re, head_b_im;
	logic                         take;

	// front: classify (operation, zero divisor) and hold
	cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.action    (action),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.take      (take),
		.head_v    (head_v),
		.head_ctl  (head_ctl),
		.head_a_re (head_a_re),
		.head_a_im (head_a_im),
		.head_b_re (head_b_re),
		.head_b_im (head_b_im)
	);

	// back: products, combine, divide, saturate, result register
	cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_v    (head_v),
		.head_ctl  (head_ctl),
		.head_a_re (head_a_re),
		.head_a_im (head_a_im),
		.head_b_re (head_b_re),
		.head_b_im (head_b_im),
		.take      (take),
		.pop       (pop),
		.empty     (empty),
		.res_re    (res_re),
		.res_im    (res_im),
		.status    (status)
	);

endmodule

[hw/rtl/cau_checker.sv]
// Port-level assertions for the complex arithmetic unit, bound to the top level.
module cau_checker #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         empty,
	input logic                         pop,
	input logic signed [DATA_WIDTH-1:0] res_re,
	input logic signed [DATA_WIDTH-1:0] res_im,
	input logic [1:0]                   status
);
	import cau_pkg::*;

	localparam logic [DATA_WIDTH-1:0] MAXV = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] MINV = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	a_no_rsvd: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> status != ST_RSVD)
		else $error("reserved status code on result");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_DIV0) |-> (res_re == '0 && res_im == '0))
		else $error("divide by zero result not cleared");

	a_ovf_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_OVF) |->
		(res_re == MAXV || res_re == MINV || res_im == MAXV || res_im == MINV))
		else $error("overflow status without a saturated part");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(res_re) && $stable(res_im)
		&& $stable(status)))
		else $error("stalled result changed");

endmodule

bind complex_arithmetic_unit cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.empty  (empty),
	.pop    (pop),
	.res_re (res_re),
	.res_im (res_im),
	.status (status)
);

[tb/sv/tb.sv]
// Testbench for the complex arithmetic unit: directed, random and back-pressure tests.
module tb;
	import cau_pkg::*;

	localparam int W    = 32;
	localparam int FRAC = 16;
	localparam logic signed [127:0] W_MAX = 128'sd2147483647;
	localparam logic signed [127:0] W_MIN = -128'sd2147483648;

	// One complex result as the block should deliver it.
	typedef struct {
		logic signed [W-1:0] re;
		logic signed [W-1:0] im;
		status_t             st;
	} cplx_res_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                push = 1'b0;
	logic                full;
	logic [1:0]          action = OP_ADD;
	logic signed [W-1:0] a_re = '0;
	logic signed [W-1:0] a_im = '0;
	logic signed [W-1:0] b_re = '0;
	logic signed [W-1:0] b_im = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic signed [W-1:0] res_re;
	logic signed [W-1:0] res_im;
	logic [1:0]          status;

	cplx_res_t result_q[$];
	int        mismatches = 0;
	int        n_sent = 0;
	int        n_checked = 0;
	int        op_count[4] = '{0, 0, 0, 0};
	int        n_div0 = 0;
	int        n_ovf = 0;
	int        send_idle_pct = 0;
	int        pop_stall_pct = 0;
	int        hold_cycles = 0;

	complex_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full),
		.action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.empty(empty), .pop(pop),
		.res_re(res_re), .res_im(res_im), .status(status)
	);

	always #4 clk = ~clk;

	// Clamp one exact part to the signed result range.
	function automatic logic signed [W-1:0] clamp(input logic signed [127:0] x,
			inout bit ovf);
		if (x > W_MAX) begin
			ovf = 1'b1;
			return W_MAX[W-1:0];
		end
		if (x < W_MIN) begin
			ovf = 1'b1;
			return W_MIN[W-1:0];
		end
		return x[W-1:0];
	endfunction

	// Exact complex arithmetic at 128 bits; signed division truncates toward zero.
	function automatic cplx_res_t complex_result(input op_t op,
			input logic signed [W-1:0] ar, ai, br, bi);
		logic signed [127:0] re, im, den;
		logic signed [127:0] one_q;
		bit                  ovf;
		cplx_res_t           r;
		ovf = 1'b0;
		one_q = 128'sd1 <<< FRAC;
		case (op)
			OP_ADD: begin
				re = ar;
				re = re + br;
				im = ai;
				im = im + bi;
			end
			OP_SUB: begin
				re = ar;
				re = re - br;
				im = ai;
				im = im - bi;
			end
			OP_MUL: begin
				re = (128'(ar) * 128'(br) - 128'(ai) * 128'(bi)) / one_q;
				im = (128'(ar) * 128'(bi) + 128'(ai) * 128'(br)) / one_q;
			end
			default: begin
				den = 128'(br) * 128'(br) + 128'(bi) * 128'(bi);
				if (den == 0) begin
					r.re = '0;
					r.im = '0;
					r.st = ST_DIV0;
					return r;
				end
				re = ((128'(ar) * 128'(br) + 128'(ai) * 128'(bi)) <<< FRAC) / den;
				im = ((128'(ai) * 128'(br) - 128'(ar) * 128'(bi)) <<< FRAC) / den;
			end
		endcase
		r.re = clamp(re, ovf);
		r.im = clamp(im, ovf);
		r.st = ovf ? ST_OVF : ST_OK;
		return r;
	endfunction

	// Offer one transaction and hold it until the queue takes it; queue its result.
	task automatic send_op(input op_t op, input logic signed [W-1:0] ar, ai, br, bi);
		cplx_res_t r;
		push   <= 1'b1;
		action <= op;
		a_re   <= ar;
		a_im   <= ai;
		b_re   <= br;
		b_im   <= bi;
		@(posedge clk);
		while (full) @(posedge clk);
		r = complex_result(op, ar, ai, br, bi);
		result_q.push_back(r);
		n_sent++;
		op_count[op]++;
		if (r.st == ST_DIV0) n_div0++;
		if (r.st == ST_OVF) n_ovf++;
	endtask

	// Drop push for a random gap, as the current sender idling asks.
	task automatic sender_gap();
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic idle_sender();
		push <= 1'b0;
		@(posedge clk);
	endtask

	// Operand mix: extremes, zero, small fractions and full-range values.
	function automatic logic signed [W-1:0] rand_operand();
		case ($urandom_range(9))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3, 4:    return $signed($urandom_range(1 << 20)) - (1 <<< 19);
			5:       return $signed($urandom_range(1 << 24)) - (1 <<< 23);
			default: return $urandom;
		endcase
	endfunction

	// Wait until every queued result has come back.
	task automatic drain();
		idle_sender();
		while (result_q.size() != 0) @(posedge clk);
	endtask

	// Receiver: pop at random unless a long hold-off is counting down.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			pop <= 1'b0;
		end else begin
			pop <= ($urandom_range(99) >= pop_stall_pct);
		end
	end

	// Check every popped transaction against the oldest expectation.
	always @(posedge clk) begin
		cplx_res_t e;
		if (arst_n && pop && !empty) begin
			if (result_q.size() == 0) begin
				$display("%0t: unexpected result re=%h im=%h status=%0d",
					$time, res_re, res_im, status);
				mismatches++;
			end else begin
				e = result_q.pop_front();
				n_checked++;
				if (res_re !== e.re) begin
					$display("%0t: res_re expected %h actual %h", $time, e.re, res_re);
					mismatches++;
				end
				if (res_im !== e.im) begin
					$display("%0t: res_im expected %h actual %h", $time, e.im, res_im);
					mismatches++;
				end
				if (status !== e.st) begin
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
					mismatches++;
				end
			end
		end
	end

	// Corners: extremes, every operation, truncation, divide by zero, saturation.
	task automatic test_directed();
		send_op(OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_op(OP_ADD, 32'sh7fffffff, 32'sh00000001, 32'sh80000000, 32'shffffffff);
		send_op(OP_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh00000001, 32'shffffffff);
		send_op(OP_SUB, 32'sh7fffffff, 0, 32'sh7fffffff, 0);
		send_op(OP_MUL, 32'sh00010000, 32'sh00020000, 32'sh00030000, 32'shfffc0000);
		send_op(OP_MUL, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_op(OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_op(OP_MUL, 32'shffffffff, 0, 32'sh00000001, 0);
		send_op(OP_MUL, 32'shffff8000, 32'sh00000003, 32'sh00000003, 32'shffffffff);
		send_op(OP_DIV, 32'sh00050000, 32'sh00010000, 0, 0);
		send_op(OP_DIV, 32'sh7fffffff, 32'sh80000000, 0, 0);
		send_op(OP_DIV, 32'sh00010000, 0, 32'sh00020000, 0);
		send_op(OP_DIV, 32'sh00030000, 32'shfffe0000, 32'sh00010000, 32'sh00010000);
		send_op(OP_DIV, 32'sh7fffffff, 32'sh7fffffff, 32'sh00000001, 0);
		send_op(OP_DIV, 32'sh80000000, 0, 32'sh00000001, 32'sh00000001);
		send_op(OP_DIV, 32'shffffffff, 32'sh00000001, 32'sh00030000, 32'shfffd0000);
		send_op(OP_DIV, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_op(OP_DIV, 32'sh00000001, 32'shffffffff, 32'sh7fffffff, 32'sh80000000);
		drain();
	endtask

	// Random operands and operations over one sender-idling and receiver-stall setting.
	task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		pop_stall_pct = stall_pct;
		repeat (n_items) begin
			send_op(op_t'($urandom_range(3)), rand_operand(), rand_operand(),
				rand_operand(), rand_operand());
			sender_gap();
		end
		drain();
		send_idle_pct = 0;
		pop_stall_pct = 0;
	endtask

	// Hold the receiver off long enough that the block fills and raises full.
	task automatic test_backpressure();
		hold_cycles = 300;
		repeat (80) send_op(op_t'($urandom_range(3)), rand_operand(), rand_operand(),
			rand_operand(), rand_operand());
		drain();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(300, 0, 0);
		test_random(300, 81, 0);
		test_random(300, 0, 81);
		test_random(300, 30, 30);
		test_backpressure();
		repeat (60) @(posedge clk);
		$display("Covered %0d transactions (add %0d, sub %0d, mul %0d, div %0d), %0d checked.",
			n_sent, op_count[OP_ADD], op_count[OP_SUB], op_count[OP_MUL],
			op_count[OP_DIV], n_checked);
		$display("Divide-by-zero cases %0d, saturated results %0d.", n_div0, n_ovf);
		if (mismatches == 0 && result_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Some tests failed");
		$finish;
	end
endmodule
